// ----- design/vgd_pkg.sv -----
// shared types and constants for the voxel grid downsampler
package vgd_pkg;

    localparam int COORD_W = 20;
    localparam int REG_W   = 19;
    localparam int SUM_W   = 41;
    localparam int DIVR_W  = 20;
    localparam int SQ_W    = 40;
    localparam logic [DIVR_W-1:0] COUNT_MAX = {DIVR_W{1'b1}};

    localparam logic [1:0] REG_MIN_RANGE  = 2'd0;
    localparam logic [1:0] REG_MAX_RANGE  = 2'd1;
    localparam logic [1:0] REG_VOXEL_SIZE = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic                      cloud_end;
    } in_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [DIVR_W-1:0]         members;
        logic                      last_out;
        logic                      table_full;
        logic                      no_voxels;
    } out_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] kx;
        logic signed [COORD_W-1:0] ky;
        logic signed [COORD_W-1:0] kz;
    } key_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] sz;
        logic [DIVR_W-1:0]       count;
    } acc_t;

endpackage

// ----- design/voxel_grid_downsample.sv -----
// top level of the voxel grid downsampler
//  channel | direction | handshake             | word
//  points  | in        | in_valid / in_ready   | in_word (px py pz cloud_end)
//  results | out       | out_valid / out_ready | out_word (centroid, members, flags)
//  config  | in        | apb psel/penable      | pwdata, paddr
// a point out of range skips the key scan, else each table entry compared takes a read and a compare state;
// the divider lanes are 41-step serial dividers, the key scan runs off one ram read port
// each centroid goes through the same divider lanes
// the table is tracked by a fill count, so no clearing pass follows reset
// a finished centroid waits in the output register while the next one divides
module voxel_grid_downsample #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  vgd_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output vgd_pkg::out_word_t out_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import vgd_pkg::*;

    localparam int IDX_W = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIV    = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_CMP    = 4'd3;
    localparam logic [3:0] S_RMW    = 4'd4;
    localparam logic [3:0] S_END    = 4'd5;
    localparam logic [3:0] S_ERD    = 4'd6;
    localparam logic [3:0] S_ESTART = 4'd7;
    localparam logic [3:0] S_EWAIT  = 4'd8;
    localparam logic [3:0] S_EPUT   = 4'd9;
    localparam logic [3:0] S_EMPTY  = 4'd10;

    logic [3:0]  state_reg, state_next;
    logic [REG_W-1:0] min_range_reg, max_range_reg, voxel_size_reg;
    logic [CNT_W-1:0] used_reg, scan_reg, emit_reg;
    logic        dropped_reg;
    logic        end_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg, z_reg;
    logic [2:0]  sq_cnt_reg;
    logic [SQ_W-1:0] prod_reg, d_reg, lo_reg, hi_reg;
    logic        out_valid_reg;
    out_word_t   out_word_reg;
    logic [DIVR_W-1:0] members_reg;

    logic        accept;
    logic        wr_cfg;
    logic signed [REG_W+1:0] sq_op;
    logic signed [2*REG_W+3:0] sq_full;
    logic        keep;
    logic        div_start;
    logic        emitting;
    logic [DIVR_W-1:0] divisor;
    logic [DIVR_W-1:0] vsize_eff;
    logic signed [SUM_W-1:0] dvd_x, dvd_y, dvd_z;
    logic [2:0]  div_done;
    logic signed [COORD_W-1:0] qx, qy, qz;
    logic signed [SUM_W-1:0] ex, ey, ez;
    key_t        key_now, key_rd;
    acc_t        acc_rd, acc_wdata;
    logic        key_we, acc_we;
    logic [IDX_W-1:0] acc_waddr, acc_raddr;
    logic        table_at_end;
    logic        slot_free;

    assign accept  = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign slot_free = !out_valid_reg;
    assign pready    = 1'b1;
    assign wr_cfg    = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MIN_RANGE:  prdata = 32'(min_range_reg);
            REG_MAX_RANGE:  prdata = 32'(max_range_reg);
            REG_VOXEL_SIZE: prdata = 32'(voxel_size_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_reg  <= '0;
            max_range_reg  <= {REG_W{1'b1}};
            voxel_size_reg <= REG_W'(512);
        end
        else if (wr_cfg)
        begin
            unique case (paddr[3:2])
                REG_MIN_RANGE:  min_range_reg  <= pwdata[REG_W-1:0];
                REG_MAX_RANGE:  max_range_reg  <= pwdata[REG_W-1:0];
                REG_VOXEL_SIZE: voxel_size_reg <= pwdata[REG_W-1:0];
                default:        ;
            endcase
        end
    end

    // squares of the point and of the range limits, one per cycle
    always_comb
    begin
        case (sq_cnt_reg)
            3'd0:    sq_op = (REG_W+2)'(x_reg);
            3'd1:    sq_op = (REG_W+2)'(y_reg);
            3'd2:    sq_op = (REG_W+2)'(z_reg);
            3'd3:    sq_op = {2'b00, min_range_reg};
            3'd4:    sq_op = {2'b00, max_range_reg};
            default: sq_op = '0;
        endcase
    end
    assign sq_full = sq_op * sq_op;
    assign keep    = !(d_reg < lo_reg || d_reg > hi_reg);

    // divider lanes serve both the voxel index and the centroid
    assign emitting  = (state_reg == S_ESTART);
    assign div_start = accept || emitting;
    assign vsize_eff = (voxel_size_reg == '0) ? DIVR_W'(1) : DIVR_W'(voxel_size_reg);
    assign divisor   = emitting ? acc_rd.count : vsize_eff;
    assign dvd_x = emitting ? acc_rd.sx : SUM_W'(in_word.px);
    assign dvd_y = emitting ? acc_rd.sy : SUM_W'(in_word.py);
    assign dvd_z = emitting ? acc_rd.sz : SUM_W'(in_word.pz);

    vgd_div u_div_x (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd_x),
                     .divisor(divisor), .done(div_done[0]), .quotient(qx));
    vgd_div u_div_y (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd_y),
                     .divisor(divisor), .done(div_done[1]), .quotient(qy));
    vgd_div u_div_z (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd_z),
                     .divisor(divisor), .done(div_done[2]), .quotient(qz));

    assign key_now.kx = qx;
    assign key_now.ky = qy;
    assign key_now.kz = qz;
    assign ex = SUM_W'(x_reg);
    assign ey = SUM_W'(y_reg);
    assign ez = SUM_W'(z_reg);

    assign table_at_end = (scan_reg == used_reg);
    assign key_we = (state_reg == S_RD) && table_at_end && (used_reg != CNT_W'(TABLE_DEPTH));
    assign acc_we = key_we || ((state_reg == S_RMW) && (acc_rd.count != COUNT_MAX));
    assign acc_waddr = scan_reg[IDX_W-1:0];
    assign acc_raddr = (state_reg == S_ERD) ? emit_reg[IDX_W-1:0] : scan_reg[IDX_W-1:0];

    always_comb
    begin
        if (state_reg == S_RMW)
        begin
            acc_wdata.sx    = acc_rd.sx + ex;
            acc_wdata.sy    = acc_rd.sy + ey;
            acc_wdata.sz    = acc_rd.sz + ez;
            acc_wdata.count = acc_rd.count + DIVR_W'(1);
        end
        else
        begin
            acc_wdata.sx    = ex;
            acc_wdata.sy    = ey;
            acc_wdata.sz    = ez;
            acc_wdata.count = DIVR_W'(1);
        end
    end

    vgd_ram #(.WIDTH($bits(key_t)), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .clk(clk), .we(key_we), .waddr(scan_reg[IDX_W-1:0]), .wdata(key_now),
        .raddr(scan_reg[IDX_W-1:0]), .rdata(key_rd)
    );

    vgd_ram #(.WIDTH($bits(acc_t)), .DEPTH(TABLE_DEPTH)) u_acc_ram (
        .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
        .raddr(acc_raddr), .rdata(acc_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept) state_next = S_DIV;
            S_DIV:    if (&div_done) state_next = keep ? S_RD : S_END;
            S_RD:     state_next = table_at_end ? S_END : S_CMP;
            S_CMP:    state_next = (key_rd == key_now) ? S_RMW : S_RD;
            S_RMW:    state_next = S_END;
            S_END:
            begin
                if (!end_reg)
                    state_next = S_IDLE;
                else if (used_reg == '0)
                    state_next = S_EMPTY;
                else
                    state_next = S_ERD;
            end
            S_ERD:    state_next = S_ESTART;
            S_ESTART: state_next = S_EWAIT;
            S_EWAIT:  if (&div_done) state_next = S_EPUT;
            S_EPUT:
            begin
                if (slot_free)
                    state_next = (emit_reg + CNT_W'(1) == used_reg) ? S_IDLE : S_ERD;
            end
            S_EMPTY:  if (slot_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            scan_reg      <= '0;
            emit_reg      <= '0;
            sq_cnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    sq_cnt_reg <= '0;
                    scan_reg   <= '0;
                end
                S_DIV:
                begin
                    if (sq_cnt_reg != 3'd6)
                        sq_cnt_reg <= sq_cnt_reg + 3'd1;
                end
                S_RD:
                begin
                    if (table_at_end)
                    begin
                        if (used_reg == CNT_W'(TABLE_DEPTH))
                            dropped_reg <= 1'b1;
                        else
                            used_reg <= used_reg + CNT_W'(1);
                    end
                end
                S_CMP:
                begin
                    if (key_rd != key_now)
                        scan_reg <= scan_reg + CNT_W'(1);
                end
                S_END:    emit_reg <= '0;
                S_EPUT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        emit_reg      <= emit_reg + CNT_W'(1);
                        if (emit_reg + CNT_W'(1) == used_reg)
                        begin
                            used_reg    <= '0;
                            dropped_reg <= 1'b0;
                        end
                    end
                end
                S_EMPTY:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        dropped_reg   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg   <= in_word.px;
            y_reg   <= in_word.py;
            z_reg   <= in_word.pz;
            end_reg <= in_word.cloud_end;
            d_reg   <= '0;
        end
        if (state_reg == S_DIV)
        begin
            if (sq_cnt_reg < 3'd5)
                prod_reg <= sq_full[SQ_W-1:0];
            case (sq_cnt_reg) inside
                3'd1, 3'd2, 3'd3: d_reg  <= d_reg + prod_reg;
                3'd4:             lo_reg <= prod_reg;
                3'd5:             hi_reg <= prod_reg;
                default: ;
            endcase
        end
        if (state_reg == S_ESTART)
            members_reg <= acc_rd.count;
        if (state_reg == S_EPUT && slot_free)
        begin
            out_word_reg.cx         <= qx;
            out_word_reg.cy         <= qy;
            out_word_reg.cz         <= qz;
            out_word_reg.members    <= members_reg;
            out_word_reg.last_out   <= (emit_reg + CNT_W'(1) == used_reg);
            out_word_reg.table_full <= dropped_reg;
            out_word_reg.no_voxels  <= 1'b0;
        end
        else if (state_reg == S_EMPTY && slot_free)
        begin
            out_word_reg.cx         <= '0;
            out_word_reg.cy         <= '0;
            out_word_reg.cz         <= '0;
            out_word_reg.members    <= '0;
            out_word_reg.last_out   <= 1'b1;
            out_word_reg.table_full <= dropped_reg;
            out_word_reg.no_voxels  <= 1'b1;
        end
    end
endmodule

// ----- design/vgd_ram.sv -----
// generic single write port ram with registered read
module vgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- design/vgd_div.sv -----
// bit-serial signed floor divider, one quotient bit per cycle
module vgd_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [vgd_pkg::SUM_W-1:0]  dividend,
    input  logic [vgd_pkg::DIVR_W-1:0]        divisor,
    output logic                              done,
    output logic signed [vgd_pkg::COORD_W-1:0] quotient
);
    import vgd_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  work_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [DIVR_W-1:0] dvs_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic              done_reg;
    logic [DIVR_W:0]   shifted;
    logic              ge;
    logic [DIVR_W:0]   rem_sub;
    logic [SUM_W-1:0]  mag;
    logic [SUM_W-1:0]  q_full;

    assign shifted = {rem_reg, work_reg[SUM_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign rem_sub = shifted - {1'b0, dvs_reg};
    // round magnitude up for negatives to get the floor
    assign mag     = work_reg + SUM_W'(rem_reg != '0);
    assign q_full  = neg_reg ? (~mag + SUM_W'(1)) : work_reg;
    assign quotient = q_full[COORD_W-1:0];
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            step_reg <= STEP_W'(SUM_W);
            done_reg <= 1'b0;
        end
        else if (step_reg != '0)
        begin
            step_reg <= step_reg - STEP_W'(1);
            done_reg <= (step_reg == STEP_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= dividend[SUM_W-1];
            work_reg <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (step_reg != '0)
        begin
            work_reg <= {work_reg[SUM_W-2:0], ge};
            rem_reg  <= ge ? rem_sub[DIVR_W-1:0] : shifted[DIVR_W-1:0];
        end
    end
endmodule

// ----- design/vgd_checker.sv -----
// port level checks for the voxel grid downsampler, with its bind
module vgd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input vgd_pkg::out_word_t out_word,
    input logic               pready
);
    import vgd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.no_voxels |-> out_word.last_out && out_word.members == '0
            && out_word.cx == '0 && out_word.cy == '0 && out_word.cz == '0)
        else $error("empty cloud result malformed");

    a_members: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.no_voxels |-> out_word.members != '0)
        else $error("voxel result with no members");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");
endmodule

bind voxel_grid_downsample vgd_checker u_vgd_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .out_word(out_word), .pready(pready)
);
